// ----- sv/ibc_pkg.sv -----
// Package for the interval bin classifier.
// Holds the request/result payload types, status and op codes and the token
// that moves along the cell row. No dependencies.
package ibc_pkg;

    localparam int MAX_BREAKS = 16;
    localparam int CNT_W      = $clog2(MAX_BREAKS + 1);
    localparam int IDX_W      = (MAX_BREAKS > 1) ? $clog2(MAX_BREAKS) : 1;
    localparam int VAL_W      = 16;
    localparam int LIM_W      = 17;
    localparam int IV_W       = 5;
    localparam int ST_W       = 3;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 17'h10000;

    localparam logic [1:0] REQ_CLEAR    = 2'd0;
    localparam logic [1:0] REQ_APPEND   = 2'd1;
    localparam logic [1:0] REQ_CLASSIFY = 2'd2;

    localparam logic [ST_W-1:0] ST_OK     = 3'd0;
    localparam logic [ST_W-1:0] ST_ABOVE  = 3'd1;
    localparam logic [ST_W-1:0] ST_BELOW  = 3'd2;
    localparam logic [ST_W-1:0] ST_BADBRK = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL   = 3'd4;
    localparam logic [ST_W-1:0] ST_EMPTY  = 3'd5;

    typedef enum logic [1:0] {
        OP_PASS  = 2'd0,
        OP_STORE = 2'd1,
        OP_FIND  = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [VAL_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [IV_W-1:0]  interval;
        logic [VAL_W-1:0] bin_lo;
        logic [LIM_W-1:0] bin_hi;
    } t_out;

    // One request in flight along the row.
    // cnt: table fill seen at accept time (STORE: target slot).
    typedef struct packed {
        logic             valid;
        t_op              op;
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] cnt;
        logic             found;
        t_out             res;
    } t_tok;

endpackage

// ----- sv/ibc_cell.sv -----
// One break-point cell of the interval bin classifier row.
// Holds one stored break and registers the passing token. Uses ibc_pkg.
module ibc_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic [ibc_pkg::IDX_W-1:0] i_index,
    input  ibc_pkg::t_tok             i_tok,
    output ibc_pkg::t_tok             o_tok
);

    logic [ibc_pkg::VAL_W-1:0] r_brk;
    ibc_pkg::t_tok             r_tok;
    ibc_pkg::t_tok             n_tok;
    logic                      w_live;
    logic                      w_hit;

    // Cell counts as filled for this request only below the fill it carries.
    assign w_live = {{(ibc_pkg::CNT_W - ibc_pkg::IDX_W){1'b0}}, i_index} < i_tok.cnt;
    assign w_hit  = r_brk <= i_tok.value;

    always_comb begin
        n_tok = i_tok;
        if (i_tok.op == ibc_pkg::OP_FIND && w_live) begin
            if (w_hit) begin
                n_tok.res.interval = ibc_pkg::IV_W'({1'b0, i_index} + 1'b1);
                n_tok.res.bin_lo   = r_brk;
            end else if (!i_tok.found) begin
                n_tok.res.bin_hi = {1'b0, r_brk};
                n_tok.found      = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_tok.valid && i_tok.op == ibc_pkg::OP_STORE &&
            i_tok.cnt[ibc_pkg::IDX_W-1:0] == i_index) begin
            r_brk <= i_tok.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_en) begin
            r_tok.valid <= n_tok.valid;
        end
        if (i_en) begin
            r_tok.op    <= n_tok.op;
            r_tok.value <= n_tok.value;
            r_tok.cnt   <= n_tok.cnt;
            r_tok.found <= n_tok.found;
            r_tok.res   <= n_tok.res;
        end
    end

    assign o_tok = r_tok;

endmodule

// ----- sv/interval_bin_classifier.sv -----
// Interval bin classifier: sorted break table with per-request interval lookup.
// Each request passes the entry register, then the register of each cell in turn.
// Throughput: one request per cycle; the row holds still while the result stalls.
// Reset (synchronous, active low): table fill cleared, limit set to unbounded,
// row emptied; stored break values are not cleared.
module interval_bin_classifier (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request channel
    input  logic                      i_in_valid,
    input  ibc_pkg::t_in              i_in_data,
    output logic                      o_in_stall,
    // result channel
    output logic                      o_out_valid,
    output ibc_pkg::t_out             o_out_data,
    input  logic                      i_out_stall,
    // upper limit register write
    input  logic                      i_cfg_valid,
    input  logic [ibc_pkg::LIM_W-1:0] i_cfg_data,
    output logic                      o_cfg_ready
);

    logic [ibc_pkg::LIM_W-1:0] r_limit;
    logic [ibc_pkg::CNT_W-1:0] r_count;
    logic [ibc_pkg::VAL_W-1:0] r_first;
    logic [ibc_pkg::VAL_W-1:0] r_last;
    logic [ibc_pkg::CNT_W-1:0] n_count;
    logic                      w_en;
    logic                      w_take;
    logic                      w_app_ok;
    ibc_pkg::t_tok             n_tok;
    ibc_pkg::t_tok             r_entry;
    ibc_pkg::t_tok             w_row [0:ibc_pkg::MAX_BREAKS];

    // The whole row advances together; hold it while the result waits.
    assign w_en        = !(w_row[ibc_pkg::MAX_BREAKS].valid && i_out_stall);
    assign o_in_stall  = !w_en;
    assign w_take      = i_in_valid && w_en;
    assign o_cfg_ready = 1'b1;

    // Entry decode: every status is settled here against the limit, fill, first and
    // last break as of this request; the row only fills in the found interval.
    always_comb begin
        n_tok          = '0;
        n_tok.valid    = i_in_valid;
        n_tok.op       = ibc_pkg::OP_PASS;
        n_tok.value    = i_in_data.value;
        n_tok.cnt      = r_count;
        n_tok.res.status = ibc_pkg::ST_OK;
        n_count        = r_count;
        w_app_ok       = 1'b0;
        case (i_in_data.req_type)
            ibc_pkg::REQ_CLEAR: begin
                n_count = '0;
            end
            ibc_pkg::REQ_APPEND: begin
                if (r_count >= ibc_pkg::CNT_W'(ibc_pkg::MAX_BREAKS)) begin
                    n_tok.res.status = ibc_pkg::ST_FULL;
                end else if ((r_count != '0 && i_in_data.value <= r_last) ||
                             {1'b0, i_in_data.value} >= r_limit) begin
                    n_tok.res.status = ibc_pkg::ST_BADBRK;
                end else begin
                    // Send the break down the row to its slot.
                    w_app_ok           = 1'b1;
                    n_tok.op           = ibc_pkg::OP_STORE;
                    n_count            = r_count + 1'b1;
                    n_tok.res.interval = ibc_pkg::IV_W'(r_count + 1'b1);
                    n_tok.res.bin_lo   = i_in_data.value;
                end
            end
            ibc_pkg::REQ_CLASSIFY: begin
                if (r_count == '0) begin
                    n_tok.res.status = ibc_pkg::ST_EMPTY;
                end else if (i_in_data.value < r_first) begin
                    n_tok.res.status = ibc_pkg::ST_BELOW;
                end else if ({1'b0, i_in_data.value} >= r_limit) begin
                    n_tok.res.status = ibc_pkg::ST_ABOVE;
                end else begin
                    // Upper bound starts at the limit; the first filled cell above the value
                    // replaces it.
                    n_tok.op         = ibc_pkg::OP_FIND;
                    n_tok.res.bin_hi = r_limit;
                end
            end
            default: begin
            end
        endcase
    end

    // Control state: fill count and limit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_limit <= ibc_pkg::LIMIT_RESET;
        end else begin
            if (w_take) begin
                r_count <= n_count;
            end
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // Shadow copies of first and last break for the entry checks.
    always_ff @(posedge i_clk) begin
        if (w_take && w_app_ok) begin
            r_last <= i_in_data.value;
            if (r_count == '0) begin
                r_first <= i_in_data.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else if (w_en) begin
            r_entry.valid <= n_tok.valid;
        end
        if (w_en) begin
            r_entry.op    <= n_tok.op;
            r_entry.value <= n_tok.value;
            r_entry.cnt   <= n_tok.cnt;
            r_entry.found <= n_tok.found;
            r_entry.res   <= n_tok.res;
        end
    end

    assign w_row[0] = r_entry;

    // Row of cells, slot i holds break i; requests pass in order, one cell per cycle
    // while not held, so each sees the table exactly as left by earlier requests.
    for (genvar g = 0; g < ibc_pkg::MAX_BREAKS; g++) begin : g_cell
        ibc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_index (ibc_pkg::IDX_W'(g)),
            .i_tok   (w_row[g]),
            .o_tok   (w_row[g+1])
        );
    end

    // Last cell's register is the result register.
    assign o_out_valid = w_row[ibc_pkg::MAX_BREAKS].valid;
    assign o_out_data  = w_row[ibc_pkg::MAX_BREAKS].res;

endmodule
